### rtl/core/tcsm_pkg.sv
// Shared types and codes of the TCP connection state machine.
`default_nettype none

package tcsm_pkg;

    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned FLAGS_W = 6;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned ATT_W   = 4;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned TMR_W   = 2;

    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned IN_TUSER_W  = FUNC_W;
    localparam int unsigned OUT_TDATA_W = 80;

    localparam logic [ATT_W-1:0] MAX_SYN_RESET = 4'd3;

    // event codes
    localparam logic [FUNC_W-1:0] FN_RX_SEG   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CONNECT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLOSE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SYN_TO   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEND     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TW_END   = 3'd5;

    // connection states
    localparam logic [STATE_W-1:0] ST_CLOSED      = 4'd0;
    localparam logic [STATE_W-1:0] ST_SYN_SENT    = 4'd1;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED = 4'd2;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_1  = 4'd3;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_2  = 4'd4;
    localparam logic [STATE_W-1:0] ST_CLOSING     = 4'd5;
    localparam logic [STATE_W-1:0] ST_TIME_WAIT   = 4'd6;
    localparam logic [STATE_W-1:0] ST_CLOSE_WAIT  = 4'd7;
    localparam logic [STATE_W-1:0] ST_LAST_ACK    = 4'd8;

    // flag bit positions
    localparam int unsigned FB_FIN = 0;
    localparam int unsigned FB_SYN = 1;
    localparam int unsigned FB_RST = 2;
    localparam int unsigned FB_PSH = 3;
    localparam int unsigned FB_ACK = 4;

    localparam logic [FLAGS_W-1:0] FL_NONE    = 6'h00;
    localparam logic [FLAGS_W-1:0] FL_SYN     = 6'h02;
    localparam logic [FLAGS_W-1:0] FL_ACK     = 6'h10;
    localparam logic [FLAGS_W-1:0] FL_FIN_ACK = 6'h11;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RESET   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SYN_TO  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_ARP_TO  = 2'd3;

    localparam logic [TMR_W-1:0] TMR_NONE      = 2'd0;
    localparam logic [TMR_W-1:0] TMR_SYN       = 2'd1;
    localparam logic [TMR_W-1:0] TMR_TIME_WAIT = 2'd2;
    localparam logic [TMR_W-1:0] TMR_STOP      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FLAGS_W-1:0] rx_flags;
        logic [SEQ_W-1:0]   rx_seq;
        logic [LEN_W-1:0]   rx_payload_len;
        logic [SEQ_W-1:0]   initial_seq;
        logic               arp_ok;
    } t_in_item;

    typedef struct packed {
        logic [STATE_W-1:0] conn_state;
        logic               send;
        logic [FLAGS_W-1:0] tx_flags;
        logic [SEQ_W-1:0]   tx_seq;
        logic [SEQ_W-1:0]   tx_ack;
        logic [ERR_W-1:0]   error_code;
        logic [TMR_W-1:0]   timer_cmd;
        logic               release_res;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/core/tcsm_in_reg.sv
// Input register stage: holds one accepted event item.
`default_nettype none

module tcsm_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  tcsm_pkg::t_in_item    i_item,
    input  wire                   i_advance,
    output logic                  o_valid,
    output tcsm_pkg::t_in_item    o_item
);

    logic               r_valid;
    tcsm_pkg::t_in_item r_item;

    // room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/core/tcsm_core.sv
// Connection state registers and the per-event next-state logic.
`default_nettype none

module tcsm_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [tcsm_pkg::ATT_W-1:0]          i_cfg_wr_data,
    input  wire                                 i_step,
    input  tcsm_pkg::t_in_item                  i_item,
    output tcsm_pkg::t_out_item                 o_result
);

    logic [tcsm_pkg::ATT_W-1:0]   r_max_syn;
    logic [tcsm_pkg::STATE_W-1:0] r_state,   n_state;
    logic [tcsm_pkg::SEQ_W-1:0]   r_seq,     n_seq;
    logic [tcsm_pkg::SEQ_W-1:0]   r_ack,     n_ack;
    logic [tcsm_pkg::FLAGS_W-1:0] r_pend,    n_pend;
    logic [tcsm_pkg::ATT_W-1:0]   r_att,     n_att;
    logic                         r_fin_seen, n_fin_seen;

    logic                         fl_fin, fl_syn, fl_rst, fl_psh, fl_ack;
    logic                         psh_add;
    logic [tcsm_pkg::SEQ_W-1:0]   rx_addend;
    logic [tcsm_pkg::SEQ_W-1:0]   rx_sum;
    logic [tcsm_pkg::ATT_W-1:0]   att_inc;
    logic [tcsm_pkg::SEQ_W-1:0]   seq_inc;
    logic [tcsm_pkg::SEQ_W-1:0]   seq_dec;
    tcsm_pkg::t_out_item          res;

    assign fl_fin = i_item.rx_flags[tcsm_pkg::FB_FIN];
    assign fl_syn = i_item.rx_flags[tcsm_pkg::FB_SYN];
    assign fl_rst = i_item.rx_flags[tcsm_pkg::FB_RST];
    assign fl_psh = i_item.rx_flags[tcsm_pkg::FB_PSH];
    assign fl_ack = i_item.rx_flags[tcsm_pkg::FB_ACK];

    // one adder serves both acknowledgement forms
    assign psh_add   = (r_state == tcsm_pkg::ST_ESTABLISHED) && fl_psh;
    assign rx_addend = psh_add ? {{(tcsm_pkg::SEQ_W-tcsm_pkg::LEN_W){1'b0}},
                                  i_item.rx_payload_len}
                               : {{(tcsm_pkg::SEQ_W-1){1'b0}}, 1'b1};
    assign rx_sum    = i_item.rx_seq + rx_addend;
    assign att_inc   = r_att + {{(tcsm_pkg::ATT_W-1){1'b0}}, 1'b1};
    assign seq_inc   = r_seq + {{(tcsm_pkg::SEQ_W-1){1'b0}}, 1'b1};
    assign seq_dec   = r_seq - {{(tcsm_pkg::SEQ_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_state    = r_state;
        n_seq      = r_seq;
        n_ack      = r_ack;
        n_pend     = r_pend;
        n_att      = r_att;
        n_fin_seen = r_fin_seen;
        res        = '0;

        unique case (i_item.func)
            tcsm_pkg::FN_RX_SEG: begin
                if (r_state != tcsm_pkg::ST_ESTABLISHED) begin
                    if (fl_syn || fl_fin) begin
                        n_ack = rx_sum;
                    end
                end else if (fl_psh || fl_fin) begin
                    n_ack = rx_sum;
                end

                unique case (r_state)
                    tcsm_pkg::ST_SYN_SENT: begin
                        if (fl_syn && fl_ack) begin
                            res.timer_cmd = tcsm_pkg::TMR_STOP;
                            n_pend        = tcsm_pkg::FL_ACK;
                            n_state       = tcsm_pkg::ST_ESTABLISHED;
                        end else if (fl_rst) begin
                            res.timer_cmd  = tcsm_pkg::TMR_STOP;
                            res.error_code = tcsm_pkg::ERR_RESET;
                            n_state        = tcsm_pkg::ST_CLOSED;
                            n_pend         = tcsm_pkg::FL_NONE;
                            n_fin_seen     = 1'b0;
                        end
                    end
                    tcsm_pkg::ST_ESTABLISHED: begin
                        if (fl_psh) begin
                            n_pend = tcsm_pkg::FL_ACK;
                        end else if (fl_fin) begin
                            n_pend     = tcsm_pkg::FL_ACK;
                            n_fin_seen = 1'b1;
                        end else if (fl_rst) begin
                            res.timer_cmd  = tcsm_pkg::TMR_STOP;
                            res.error_code = tcsm_pkg::ERR_RESET;
                            n_state        = tcsm_pkg::ST_CLOSED;
                            n_pend         = tcsm_pkg::FL_NONE;
                            n_fin_seen     = 1'b0;
                        end
                    end
                    tcsm_pkg::ST_LAST_ACK: begin
                        if (fl_ack || fl_rst) begin
                            res.release_res = 1'b1;
                            n_state         = tcsm_pkg::ST_CLOSED;
                            n_pend          = tcsm_pkg::FL_NONE;
                            n_fin_seen      = 1'b0;
                        end
                    end
                    tcsm_pkg::ST_FIN_WAIT_1: begin
                        if (fl_fin) begin
                            n_pend  = tcsm_pkg::FL_ACK;
                            n_state = tcsm_pkg::ST_CLOSING;
                        end else if (fl_rst) begin
                            res.timer_cmd  = tcsm_pkg::TMR_STOP;
                            res.error_code = tcsm_pkg::ERR_RESET;
                            n_state        = tcsm_pkg::ST_CLOSED;
                            n_pend         = tcsm_pkg::FL_NONE;
                            n_fin_seen     = 1'b0;
                        end else if (fl_ack) begin
                            n_state = tcsm_pkg::ST_FIN_WAIT_2;
                        end
                    end
                    tcsm_pkg::ST_CLOSING: begin
                        if (fl_rst) begin
                            res.timer_cmd  = tcsm_pkg::TMR_STOP;
                            res.error_code = tcsm_pkg::ERR_RESET;
                            n_state        = tcsm_pkg::ST_CLOSED;
                            n_pend         = tcsm_pkg::FL_NONE;
                            n_fin_seen     = 1'b0;
                        end else if (fl_ack) begin
                            n_state       = tcsm_pkg::ST_TIME_WAIT;
                            res.timer_cmd = tcsm_pkg::TMR_TIME_WAIT;
                        end
                    end
                    tcsm_pkg::ST_FIN_WAIT_2: begin
                        if (fl_fin) begin
                            n_pend        = tcsm_pkg::FL_ACK;
                            n_state       = tcsm_pkg::ST_TIME_WAIT;
                            res.timer_cmd = tcsm_pkg::TMR_TIME_WAIT;
                        end else if (fl_rst) begin
                            res.timer_cmd  = tcsm_pkg::TMR_STOP;
                            res.error_code = tcsm_pkg::ERR_RESET;
                            n_state        = tcsm_pkg::ST_CLOSED;
                            n_pend         = tcsm_pkg::FL_NONE;
                            n_fin_seen     = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tcsm_pkg::FN_CONNECT: begin
                if (r_state == tcsm_pkg::ST_CLOSED) begin
                    if (i_item.arp_ok) begin
                        n_seq      = i_item.initial_seq;
                        n_ack      = '0;
                        n_att      = '0;
                        n_fin_seen = 1'b0;
                        n_state    = tcsm_pkg::ST_SYN_SENT;
                        n_pend     = tcsm_pkg::FL_SYN;
                    end else begin
                        res.error_code = tcsm_pkg::ERR_ARP_TO;
                        n_pend         = tcsm_pkg::FL_NONE;
                        n_fin_seen     = 1'b0;
                    end
                end
            end
            tcsm_pkg::FN_CLOSE: begin
                if (r_state == tcsm_pkg::ST_ESTABLISHED) begin
                    n_pend  = tcsm_pkg::FL_FIN_ACK;
                    n_state = tcsm_pkg::ST_FIN_WAIT_1;
                end else if (r_state == tcsm_pkg::ST_CLOSE_WAIT) begin
                    n_pend  = tcsm_pkg::FL_FIN_ACK;
                    n_state = tcsm_pkg::ST_LAST_ACK;
                end
            end
            tcsm_pkg::FN_SYN_TO: begin
                if (r_state == tcsm_pkg::ST_SYN_SENT) begin
                    if (att_inc >= r_max_syn) begin
                        // give up the connect
                        n_att          = '0;
                        res.error_code = tcsm_pkg::ERR_SYN_TO;
                        n_state        = tcsm_pkg::ST_CLOSED;
                        n_pend         = tcsm_pkg::FL_NONE;
                        n_fin_seen     = 1'b0;
                    end else begin
                        // rewind so the resent SYN carries the same number
                        n_att  = att_inc;
                        n_seq  = seq_dec;
                        n_pend = tcsm_pkg::FL_SYN;
                    end
                end
            end
            tcsm_pkg::FN_SEND: begin
                if (r_pend != tcsm_pkg::FL_NONE) begin
                    res.send     = 1'b1;
                    res.tx_flags = r_pend;
                    res.tx_seq   = r_seq;
                    res.tx_ack   = r_ack;
                    if (r_state == tcsm_pkg::ST_SYN_SENT) begin
                        res.timer_cmd = tcsm_pkg::TMR_SYN;
                    end else if (r_state == tcsm_pkg::ST_ESTABLISHED) begin
                        if (r_pend[tcsm_pkg::FB_ACK] && r_fin_seen) begin
                            n_state    = tcsm_pkg::ST_CLOSE_WAIT;
                            n_fin_seen = 1'b0;
                        end
                    end
                    if (r_pend[tcsm_pkg::FB_SYN] || r_pend[tcsm_pkg::FB_FIN]) begin
                        n_seq = seq_inc;
                    end
                    n_pend = tcsm_pkg::FL_NONE;
                end
            end
            tcsm_pkg::FN_TW_END: begin
                if (r_state == tcsm_pkg::ST_TIME_WAIT) begin
                    res.release_res = 1'b1;
                    n_state         = tcsm_pkg::ST_CLOSED;
                    n_pend          = tcsm_pkg::FL_NONE;
                    n_fin_seen      = 1'b0;
                end
            end
            default: begin
            end
        endcase

        res.conn_state = n_state;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_syn <= tcsm_pkg::MAX_SYN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_syn <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcsm_pkg::ST_CLOSED;
            r_seq      <= '0;
            r_ack      <= '0;
            r_pend     <= tcsm_pkg::FL_NONE;
            r_att      <= '0;
            r_fin_seen <= 1'b0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_seq      <= n_seq;
            r_ack      <= n_ack;
            r_pend     <= n_pend;
            r_att      <= n_att;
            r_fin_seen <= n_fin_seen;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tcsm_out_reg.sv
// Result register: holds one result item until the sink takes it.
`default_nettype none

module tcsm_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  tcsm_pkg::t_out_item   i_result,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire                   i_ready,
    output tcsm_pkg::t_out_item   o_result
);

    logic                r_valid;
    tcsm_pkg::t_out_item r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### rtl/core/tcp_connection_state_machine.sv
// Top level of the client-side TCP connection state machine.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid/tready       | tuser: func; tdata: event fields
//  m_axis    | out | m_axis_tvalid/tready       | tdata: result fields
//  cfg       | in  | i_cfg_wr_en (no wait)      | i_cfg_wr_data: max_syn_attempts
//
// One event item per cycle sustained while the sink keeps taking results; a
// result leaves through the input register, then the result register.
// The connection state update sits between the two registers: two 32-bit adds and one 32-bit subtract.
// Reset is synchronous, active low, and returns the connection to CLOSED.
// A stalled sink holds the result; the input register takes one more item only if it is empty.
`default_nettype none

module tcp_connection_state_machine (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [tcsm_pkg::ATT_W-1:0]          i_cfg_wr_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] rx_flags, [37:6] rx_seq, [53:38] rx_payload_len,
    // [85:54] initial_seq, [86] arp_ok, [87] zero
    input  wire  [tcsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] func
    input  wire  [tcsm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [3:0] conn_state, [4] send, [10:5] tx_flags, [42:11] tx_seq,
    // [74:43] tx_ack, [76:75] error_code, [78:77] timer_cmd, [79] release_res
    output logic [tcsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    tcsm_pkg::t_in_item  in_item;
    tcsm_pkg::t_in_item  held_item;
    tcsm_pkg::t_out_item core_result;
    tcsm_pkg::t_out_item out_result;
    logic                held_valid;
    logic                out_can_load;
    logic                step;

    assign in_item.func           = s_axis_tuser;
    assign in_item.rx_flags       = s_axis_tdata[5:0];
    assign in_item.rx_seq         = s_axis_tdata[37:6];
    assign in_item.rx_payload_len = s_axis_tdata[53:38];
    assign in_item.initial_seq    = s_axis_tdata[85:54];
    assign in_item.arp_ok         = s_axis_tdata[86];

    // advance the held item when the result register has room
    assign step = held_valid && out_can_load;

    tcsm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (step),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    tcsm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (held_item),
        .o_result      (core_result)
    );

    tcsm_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {out_result.release_res,
                           out_result.timer_cmd,
                           out_result.error_code,
                           out_result.tx_ack,
                           out_result.tx_seq,
                           out_result.tx_flags,
                           out_result.send,
                           out_result.conn_state};

endmodule

`default_nettype wire

### rtl/core/tcsm_checker.sv
// Port-level checks of the TCP connection state machine, bound to the top.
`default_nettype none

module tcsm_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [tcsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [tcsm_pkg::STATE_W-1:0] c_state;
    logic                         c_send;
    logic                         c_rel;
    logic [tcsm_pkg::ERR_W-1:0]   c_err;

    assign c_state = m_axis_tdata[3:0];
    assign c_send  = m_axis_tdata[4];
    assign c_err   = m_axis_tdata[76:75];
    assign c_rel   = m_axis_tdata[79];

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !c_send |-> m_axis_tdata[74:5] == '0)
        else $error("segment fields set without send");

    a_release_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_rel |->
            c_state == tcsm_pkg::ST_CLOSED && c_err == tcsm_pkg::ERR_NONE && !c_send)
        else $error("release outside CLOSED");

    a_error_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_err != tcsm_pkg::ERR_NONE |->
            c_state == tcsm_pkg::ST_CLOSED && !c_send)
        else $error("error without abort to CLOSED");

endmodule

bind tcp_connection_state_machine tcsm_checker u_tcsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the TCP connection state machine: directed and random events.
`timescale 1ns / 100ps

module tb;
    import tcsm_pkg::*;

    localparam logic [FLAGS_W-1:0] F_FIN = FLAGS_W'(1 << FB_FIN);
    localparam logic [FLAGS_W-1:0] F_RST = FLAGS_W'(1 << FB_RST);
    localparam logic [FLAGS_W-1:0] F_PSH = FLAGS_W'(1 << FB_PSH);
    localparam int unsigned        FB_URG = 5;
    localparam logic [FLAGS_W-1:0] F_URG = FLAGS_W'(1 << FB_URG);
    localparam logic [FLAGS_W-1:0] F_SYN_ACK = FL_SYN | FL_ACK;

    // event codes the block does not define; it must report the state and nothing else
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam int unsigned MAX_REPORTS = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [ATT_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    tcp_connection_state_machine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predicted connection context
    logic [STATE_W-1:0] cs_state   = ST_CLOSED;
    logic [SEQ_W-1:0]   cs_seq     = '0;
    logic [SEQ_W-1:0]   cs_ack     = '0;
    logic [FLAGS_W-1:0] cs_pend    = FL_NONE;
    logic [ATT_W-1:0]   cs_syn_cnt = '0;
    logic               cs_fin_seen = 1'b0;
    logic [ATT_W-1:0]   cs_max_syn = MAX_SYN_RESET;

    t_out_item   results_due[$];
    int unsigned n_fail = 0;
    int unsigned n_reports = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_req = 0;
    int unsigned stall_left = 0;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advance the predicted connection by one event and give its result
    task automatic step_connection(input t_in_item ev, output t_out_item r);
        logic fin, syn, rst, psh, ack;
        logic peer_rst, released, to_closed;
        fin = ev.rx_flags[FB_FIN];
        syn = ev.rx_flags[FB_SYN];
        rst = ev.rx_flags[FB_RST];
        psh = ev.rx_flags[FB_PSH];
        ack = ev.rx_flags[FB_ACK];
        peer_rst = 1'b0;
        released = 1'b0;
        to_closed = 1'b0;
        r = '0;
        case (ev.func)
            FN_RX_SEG: begin
                if (cs_state != ST_ESTABLISHED) begin
                    if (syn || fin) cs_ack = ev.rx_seq + SEQ_W'(1);
                end else if (psh) begin
                    cs_ack = ev.rx_seq + SEQ_W'(ev.rx_payload_len);
                end else if (fin) begin
                    cs_ack = ev.rx_seq + SEQ_W'(1);
                end
                case (cs_state)
                    ST_SYN_SENT: begin
                        if (syn && ack) begin
                            r.timer_cmd = TMR_STOP;
                            cs_pend = FL_ACK;
                            cs_state = ST_ESTABLISHED;
                        end else if (rst) begin
                            peer_rst = 1'b1;
                        end
                    end
                    ST_ESTABLISHED: begin
                        if (psh) begin
                            cs_pend = FL_ACK;
                        end else if (fin) begin
                            cs_pend = FL_ACK;
                            cs_fin_seen = 1'b1;
                        end else if (rst) begin
                            peer_rst = 1'b1;
                        end
                    end
                    ST_LAST_ACK: begin
                        if (ack || rst) released = 1'b1;
                    end
                    ST_FIN_WAIT_1: begin
                        if (fin) begin
                            cs_pend = FL_ACK;
                            cs_state = ST_CLOSING;
                        end else if (rst) begin
                            peer_rst = 1'b1;
                        end else if (ack) begin
                            cs_state = ST_FIN_WAIT_2;
                        end
                    end
                    ST_CLOSING: begin
                        if (rst) begin
                            peer_rst = 1'b1;
                        end else if (ack) begin
                            cs_state = ST_TIME_WAIT;
                            r.timer_cmd = TMR_TIME_WAIT;
                        end
                    end
                    ST_FIN_WAIT_2: begin
                        if (fin) begin
                            cs_pend = FL_ACK;
                            cs_state = ST_TIME_WAIT;
                            r.timer_cmd = TMR_TIME_WAIT;
                        end else if (rst) begin
                            peer_rst = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            FN_CONNECT: begin
                if (cs_state == ST_CLOSED) begin
                    if (ev.arp_ok) begin
                        cs_seq = ev.initial_seq;
                        cs_ack = '0;
                        cs_syn_cnt = '0;
                        cs_fin_seen = 1'b0;
                        cs_state = ST_SYN_SENT;
                        cs_pend = FL_SYN;
                    end else begin
                        r.error_code = ERR_ARP_TO;
                        to_closed = 1'b1;
                    end
                end
            end
            FN_CLOSE: begin
                if (cs_state == ST_ESTABLISHED) begin
                    cs_pend = FL_FIN_ACK;
                    cs_state = ST_FIN_WAIT_1;
                end else if (cs_state == ST_CLOSE_WAIT) begin
                    cs_pend = FL_FIN_ACK;
                    cs_state = ST_LAST_ACK;
                end
            end
            FN_SYN_TO: begin
                if (cs_state == ST_SYN_SENT) begin
                    cs_syn_cnt = cs_syn_cnt + ATT_W'(1);
                    if (cs_syn_cnt >= cs_max_syn) begin
                        cs_syn_cnt = '0;
                        r.error_code = ERR_SYN_TO;
                        to_closed = 1'b1;
                    end else begin
                        cs_seq = cs_seq - SEQ_W'(1);
                        cs_pend = FL_SYN;
                    end
                end
            end
            FN_SEND: begin
                if (cs_pend != FL_NONE) begin
                    r.send = 1'b1;
                    r.tx_flags = cs_pend;
                    r.tx_seq = cs_seq;
                    r.tx_ack = cs_ack;
                    if (cs_state == ST_SYN_SENT) begin
                        r.timer_cmd = TMR_SYN;
                    end else if (cs_state == ST_ESTABLISHED && cs_pend[FB_ACK] && cs_fin_seen) begin
                        cs_state = ST_CLOSE_WAIT;
                        cs_fin_seen = 1'b0;
                    end
                    if ((cs_pend & (FL_SYN | F_FIN)) != FL_NONE) cs_seq = cs_seq + SEQ_W'(1);
                    cs_pend = FL_NONE;
                end
            end
            FN_TW_END: begin
                if (cs_state == ST_TIME_WAIT) released = 1'b1;
            end
            default: ;
        endcase
        if (peer_rst) begin
            r.timer_cmd = TMR_STOP;
            r.error_code = ERR_RESET;
            to_closed = 1'b1;
        end
        if (released) begin
            r.release_res = 1'b1;
            to_closed = 1'b1;
        end
        if (to_closed) begin
            cs_state = ST_CLOSED;
            cs_pend = FL_NONE;
            cs_fin_seen = 1'b0;
        end
        r.conn_state = cs_state;
    endtask

    function automatic t_in_item ev_of(logic [FUNC_W-1:0] func, logic [FLAGS_W-1:0] flags,
                                       logic [SEQ_W-1:0] rseq, logic [LEN_W-1:0] len,
                                       logic [SEQ_W-1:0] iseq, logic arp);
        t_in_item ev;
        ev.func = func;
        ev.rx_flags = flags;
        ev.rx_seq = rseq;
        ev.rx_payload_len = len;
        ev.initial_seq = iseq;
        ev.arp_ok = arp;
        return ev;
    endfunction

    // mostly events that move the connection along from its predicted state
    function automatic t_in_item pick_event();
        t_in_item    ev;
        int unsigned roll;
        ev = ev_of(FN_RX_SEG, FL_NONE, $urandom,
                   ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 1460)),
                   $urandom, $urandom_range(0, 9) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            ev.func = FUNC_W'($urandom_range(0, 7));
            ev.rx_flags = FLAGS_W'($urandom);
            ev.arp_ok = 1'($urandom);
            return ev;
        end
        if (cs_pend != FL_NONE && roll < 60) begin
            ev.func = FN_SEND;
            return ev;
        end
        roll = $urandom_range(0, 99);
        case (cs_state)
            ST_CLOSED: ev.func = FN_CONNECT;
            ST_SYN_SENT: begin
                if (roll < 55) ev.rx_flags = F_SYN_ACK;
                else if (roll < 92) ev.func = FN_SYN_TO;
                else ev.rx_flags = F_RST;
            end
            ST_ESTABLISHED: begin
                if (roll < 55) ev.rx_flags = F_PSH | FL_ACK;
                else if (roll < 70) ev.rx_flags = FL_FIN_ACK;
                else if (roll < 95) ev.func = FN_CLOSE;
                else ev.rx_flags = F_RST;
            end
            ST_FIN_WAIT_1: begin
                if (roll < 50) ev.rx_flags = FL_ACK;
                else if (roll < 90) ev.rx_flags = FL_FIN_ACK;
                else ev.rx_flags = F_RST;
            end
            ST_FIN_WAIT_2: ev.rx_flags = (roll < 85) ? FL_FIN_ACK : F_RST;
            ST_CLOSING:    ev.rx_flags = (roll < 85) ? FL_ACK : F_RST;
            ST_TIME_WAIT: begin
                if (roll < 85) ev.func = FN_TW_END;
                else ev.rx_flags = FL_FIN_ACK;
            end
            ST_CLOSE_WAIT: begin
                if (roll < 85) ev.func = FN_CLOSE;
                else ev.rx_flags = FLAGS_W'($urandom);
            end
            ST_LAST_ACK: ev.rx_flags = (roll < 85) ? FL_ACK : F_RST;
            default: ;
        endcase
        if (ev.func == FN_RX_SEG && $urandom_range(0, 4) == 0)
            ev.rx_flags = ev.rx_flags | (FLAGS_W'($urandom) & (F_URG | F_PSH));
        return ev;
    endfunction

    task automatic send_event(input t_in_item ev);
        int unsigned gap;
        t_out_item   due;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, ev.arp_ok, ev.initial_seq, ev.rx_payload_len, ev.rx_seq,
                         ev.rx_flags};
        s_axis_tuser <= ev.func;
        do @(posedge i_clk); while (!s_axis_tready);
        step_connection(ev, due);
        results_due.push_back(due);
    endtask

    // hold the input side until every result is out and the pipeline is empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_syn(input logic [ATT_W-1:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cs_max_syn = value;
    endtask

    task automatic test_passive_close();
        send_event(ev_of(FN_SPARE_7, '1, '1, '1, '1, 1'b1));
        send_event(ev_of(FN_SPARE_6, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_RX_SEG, FL_SYN, '1, '0, '0, 1'b0));
        send_event(ev_of(FN_CLOSE, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_SYN_TO, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_TW_END, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_CONNECT, FL_NONE, '0, '0, '1, 1'b0));
        send_event(ev_of(FN_CONNECT, FL_NONE, '0, '0, '1, 1'b1));
        send_event(ev_of(FN_CONNECT, FL_NONE, '0, '0, 32'h1234_5678, 1'b1));
        // sequence number wraps on the SYN and backs up on the retry
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_SYN_TO, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_RX_SEG, F_SYN_ACK, 32'h8000_0000, '0, '0, 1'b0));
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_RX_SEG, F_PSH | FL_ACK, '1, '1, '0, 1'b0));
        send_event(ev_of(FN_RX_SEG, FL_FIN_ACK, '0, '1, '0, 1'b0));
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_CLOSE, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
        send_event(ev_of(FN_RX_SEG, FL_ACK, '0, '0, '0, 1'b0));
    endtask

    // retry every SYN until the connect gives up with the timeout error
    task automatic test_syn_limit(input logic [ATT_W-1:0] limit);
        write_max_syn(limit);
        send_event(ev_of(FN_CONNECT, FL_NONE, '0, '0, $urandom, 1'b1));
        repeat (limit) begin
            send_event(ev_of(FN_SEND, FL_NONE, '0, '0, '0, 1'b0));
            send_event(ev_of(FN_SYN_TO, FL_NONE, '0, '0, '0, 1'b0));
        end
    endtask

    task automatic test_input_stall();
        drain_results();
        idle_on = 1'b0;
        hold_req = 60;
        repeat (40) send_event(pick_event());
        idle_on = 1'b1;
    endtask

    task automatic test_random_sessions();
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: write_max_syn(4'd15);
                1: write_max_syn(4'd1);
                default: write_max_syn(ATT_W'($urandom_range(1, 15)));
            endcase
            idle_on = (phase % 4) != 3;
            repeat (200) send_event(pick_event());
        end
        idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin : sink_pacing
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end else if (stall_left == 0 && idle_on) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got, inout bit bad);
        if (want !== got) begin
            bad = 1'b1;
            if (n_reports < MAX_REPORTS) begin
                n_reports++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        bit        bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                n_fail++;
                if (n_reports < MAX_REPORTS) begin
                    n_reports++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                end
            end else begin
                want = results_due.pop_front();
                bad = 1'b0;
                check_field("conn_state", SEQ_W'(want.conn_state),
                            SEQ_W'(m_axis_tdata[3:0]), bad);
                check_field("send", SEQ_W'(want.send), SEQ_W'(m_axis_tdata[4]), bad);
                check_field("tx_flags", SEQ_W'(want.tx_flags),
                            SEQ_W'(m_axis_tdata[10:5]), bad);
                check_field("tx_seq", want.tx_seq, m_axis_tdata[42:11], bad);
                check_field("tx_ack", want.tx_ack, m_axis_tdata[74:43], bad);
                check_field("error_code", SEQ_W'(want.error_code),
                            SEQ_W'(m_axis_tdata[76:75]), bad);
                check_field("timer_cmd", SEQ_W'(want.timer_cmd),
                            SEQ_W'(m_axis_tdata[78:77]), bad);
                check_field("release_res", SEQ_W'(want.release_res),
                            SEQ_W'(m_axis_tdata[79]), bad);
                if (bad) n_fail++;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passive_close();
        test_syn_limit(4'd15);
        test_syn_limit(4'd1);
        test_input_stall();
        test_random_sessions();
        drain_results();
        repeat (6) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
